// File: design/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine: default sizes,
// register map, state machine encodings and the merge request bundle.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Default sizes
  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned KeyBitsDef  = 32;

  // Fixed field widths
  localparam int unsigned KeyW  = 32;
  localparam int unsigned TagW  = 16;
  localparam int unsigned DataW = 32;

  // Index width that covers every element address of the largest set
  localparam int unsigned IdxW = 6;

  // Register map: byte address, one 32-bit word per register
  localparam int unsigned AddrW   = 3;
  localparam int unsigned RegIdxW = AddrW - 2;
  localparam logic [RegIdxW-1:0] RegAscending = '0;

  // Core sequencer states
  typedef enum logic [2:0] {
    CORE_LOAD,
    CORE_SORT,
    CORE_MERGE,
    CORE_COPY,
    CORE_EMIT
  } core_state_e;

  // Recursion sequencer states
  typedef enum logic [1:0] {
    SORT_IDLE,
    SORT_FRAME,
    SORT_WAIT
  } sort_state_e;

  // Progress of one range on the recursion stack
  typedef enum logic [1:0] {
    FS_SPLIT,
    FS_RIGHT,
    FS_MERGE
  } frame_stage_e;

  // Merge of the runs [low..mid] and [mid+1..high]
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] low;
    logic [IdxW-1:0] mid;
    logic [IdxW-1:0] high;
  } merge_req_t;

endpackage

// File: design/mse_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_sorter
// Top-down recursion sequencer. Walks the split tree of the loaded set with
// a small frame stack and issues one merge request per inner node, in the
// post-order of a recursive top-down merge sort.
// ----------------------------------------------------------------------------
module mse_sorter #(
  parameter int unsigned MaxItems = mse_pkg::MaxItemsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mse_pkg::IdxW-1:0]  last_idx_i,
  input  logic                      merge_done_i,
  output mse_pkg::merge_req_t       req_o,
  output logic                      done_o
);

  localparam int unsigned AW    = $clog2(MaxItems);
  localparam int unsigned Depth = AW + 1;
  localparam int unsigned IW    = $clog2(Depth);
  localparam int unsigned SPW   = $clog2(Depth + 1);

  mse_pkg::sort_state_e state_q, state_d;
  logic [SPW-1:0]       sp_q, sp_d;

  // Frame stack
  logic [AW-1:0]         frm_low_q   [Depth];
  logic [AW-1:0]         frm_high_q  [Depth];
  mse_pkg::frame_stage_e frm_stage_q [Depth];

  logic [IW-1:0]         top_idx;
  logic [IW-1:0]         push_idx;
  logic [AW-1:0]         top_low;
  logic [AW-1:0]         top_high;
  mse_pkg::frame_stage_e top_stage;
  logic [AW:0]           mid_sum;
  logic [AW-1:0]         top_mid;

  logic                  push_en;
  logic [AW-1:0]         push_low;
  logic [AW-1:0]         push_high;
  logic                  stage_we;
  mse_pkg::frame_stage_e stage_val;

  // Look at the top frame
  assign top_idx   = IW'(sp_q - SPW'(1));
  assign push_idx  = sp_q[IW-1:0];
  assign top_low   = frm_low_q[top_idx];
  assign top_high  = frm_high_q[top_idx];
  assign top_stage = frm_stage_q[top_idx];
  assign mid_sum   = {1'b0, top_low} + {1'b0, top_high};
  assign top_mid   = mid_sum[AW:1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mse_pkg::SORT_IDLE: begin
        if (start_i) state_d = mse_pkg::SORT_FRAME;
      end
      mse_pkg::SORT_FRAME: begin
        if (sp_q == '0) begin
          state_d = mse_pkg::SORT_IDLE;
        end else if (top_stage == mse_pkg::FS_MERGE) begin
          state_d = mse_pkg::SORT_WAIT;
        end
      end
      mse_pkg::SORT_WAIT: begin
        if (merge_done_i) state_d = mse_pkg::SORT_FRAME;
      end
      default: state_d = mse_pkg::SORT_IDLE;
    endcase
  end

  // Stack moves and requests
  always_comb begin
    sp_d       = sp_q;
    push_en    = 1'b0;
    push_low   = top_low;
    push_high  = top_high;
    stage_we   = 1'b0;
    stage_val  = mse_pkg::FS_SPLIT;
    done_o     = 1'b0;
    req_o      = '0;
    req_o.low  = mse_pkg::IdxW'(top_low);
    req_o.mid  = mse_pkg::IdxW'(top_mid);
    req_o.high = mse_pkg::IdxW'(top_high);
    case (state_q)
      mse_pkg::SORT_IDLE: begin
        // open the whole set as the root range
        if (start_i) begin
          push_en   = 1'b1;
          push_low  = '0;
          push_high = AW'(last_idx_i);
          sp_d      = sp_q + SPW'(1);
        end
      end
      mse_pkg::SORT_FRAME: begin
        if (sp_q == '0) begin
          done_o = 1'b1;
        end else begin
          case (top_stage)
            mse_pkg::FS_SPLIT: begin
              if (top_low >= top_high) begin
                // single element: nothing to merge
                sp_d = sp_q - SPW'(1);
              end else begin
                stage_we  = 1'b1;
                stage_val = mse_pkg::FS_RIGHT;
                push_en   = 1'b1;
                push_low  = top_low;
                push_high = top_mid;
                sp_d      = sp_q + SPW'(1);
              end
            end
            mse_pkg::FS_RIGHT: begin
              stage_we  = 1'b1;
              stage_val = mse_pkg::FS_MERGE;
              push_en   = 1'b1;
              push_low  = top_mid + AW'(1);
              push_high = top_high;
              sp_d      = sp_q + SPW'(1);
            end
            mse_pkg::FS_MERGE: begin
              req_o.valid = 1'b1;
            end
            default: begin
              sp_d = sp_q - SPW'(1);
            end
          endcase
        end
      end
      mse_pkg::SORT_WAIT: begin
        // drop the merged range
        if (merge_done_i) sp_d = sp_q - SPW'(1);
      end
      default: begin
        sp_d = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::SORT_IDLE;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
    end
  end

  // Frame stack storage
  always_ff @(posedge clk_i) begin
    if (stage_we) frm_stage_q[top_idx] <= stage_val;
    if (push_en) begin
      frm_low_q[push_idx]   <= push_low;
      frm_high_q[push_idx]  <= push_high;
      frm_stage_q[push_idx] <= mse_pkg::FS_SPLIT;
    end
  end

endmodule

// File: design/merge_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine
// Loads a set of signed keys with tags, merge sorts the set in an element
// memory and a scratch memory, then streams the elements out in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (key_i, tag_i, last_item_i) load one element each, one per
//   cycle while in_ready_o is high. Beats past MaxItems elements are dropped.
//   The beat with last_item_i set starts the sort; in_ready_o stays low until
//   the last sorted element has been handed to the output register.
//   The sort is a top-down merge sort: a frame stack walks the split tree and
//   each merge reads both runs from the element memory (two read ports), one
//   element per cycle into the scratch memory, then copies the range back,
//   again one element per cycle. A sorted set is then emitted at one beat per
//   cycle while the receiver accepts beats.
//   Results leave through an output register; a stalled receiver holds the
//   beat and the stream, and a new set may load while the final beat waits.
//   Ties in key are taken from the right run first.
//   The ascending register (address 0, reset 1) picks the order; write it only
//   while the block is idle. Reset empties the set; memory contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int unsigned MaxItems = mse_pkg::MaxItemsDef,
  parameter int unsigned KeyBits  = mse_pkg::KeyBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mse_pkg::AddrW-1:0]         paddr,
  input  logic [mse_pkg::DataW-1:0]         pwdata,
  output logic [mse_pkg::DataW-1:0]         prdata,
  output logic                              pready,
  // load channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mse_pkg::KeyW-1:0]   key_i,
  input  logic [mse_pkg::TagW-1:0]          tag_i,
  input  logic                              last_item_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mse_pkg::KeyW-1:0]   sorted_key_o,
  output logic [mse_pkg::TagW-1:0]          sorted_tag_o,
  output logic                              last_out_o
);

  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);
  localparam int unsigned EW = KeyBits + mse_pkg::TagW;
  localparam logic [KeyBits-1:0] SignBit = {1'b1, {(KeyBits-1){1'b0}}};

  // Control state
  mse_pkg::core_state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 asc_q, asc_d;
  logic                 out_valid_q, out_valid_d;

  // Sequencing payload
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [AW-1:0] hi_q, hi_d;

  // Output register
  logic [mse_pkg::KeyW-1:0] out_key_q, out_key_d;
  logic [mse_pkg::TagW-1:0] out_tag_q, out_tag_d;
  logic                     out_last_q, out_last_d;

  // Memories and their ports
  logic [EW-1:0] elem_mem    [MaxItems];
  logic [EW-1:0] scratch_mem [MaxItems];
  logic [EW-1:0] rd0_q, rd1_q, rdb_q;
  logic          a_we;
  logic [AW-1:0] a_waddr;
  logic [EW-1:0] a_wdata;
  logic          b_we;
  logic [EW-1:0] b_wdata;

  // Sorter link
  mse_pkg::merge_req_t       req;
  logic                      sort_start;
  logic                      sort_done;
  logic                      merge_done;
  logic [mse_pkg::IdxW-1:0]  last_idx;

  // Misc
  logic                      cfg_we;
  logic                      in_acc;
  logic                      out_load;
  logic                      emit_last;
  logic [KeyBits+mse_pkg::KeyW-1:0] key_in_ext;
  logic [KeyBits+mse_pkg::KeyW-1:0] key_out_ext;
  logic [KeyBits-1:0]        key_in;
  logic [KeyBits-1:0]        l_ord, r_ord;
  logic                      left_wins;
  logic                      i_live, j_live;
  logic                      take_left;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[mse_pkg::AddrW-1:2] == mse_pkg::RegAscending);
  assign asc_d  = cfg_we ? pwdata[0] : asc_q;
  assign prdata = (paddr[mse_pkg::AddrW-1:2] == mse_pkg::RegAscending)
                  ? {{(mse_pkg::DataW-1){1'b0}}, asc_q} : '0;

  // Handshakes
  assign in_ready_o  = (state_q == mse_pkg::CORE_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_load    = !out_valid_q || out_ready_i;
  assign emit_last   = (i_q == count_q - CW'(1));
  assign out_valid_o = out_valid_q;
  assign sorted_key_o = out_key_q;
  assign sorted_tag_o = out_tag_q;
  assign last_out_o   = out_last_q;

  // Key width adaption in and out
  assign key_in_ext  = {{KeyBits{1'b0}}, key_i};
  assign key_in      = key_in_ext[KeyBits-1:0];
  assign key_out_ext = {{mse_pkg::KeyW{1'b0}}, rd0_q[EW-1 -: KeyBits]};

  // Root range of the set just closed
  assign sort_start = in_acc && last_item_i;
  assign last_idx   = (count_q == CW'(MaxItems)) ? mse_pkg::IdxW'(MaxItems - 1)
                                                  : mse_pkg::IdxW'(count_q);

  // Merge compare: flip sign bits for an unsigned order, right run wins ties
  assign l_ord     = rd0_q[EW-1 -: KeyBits] ^ SignBit;
  assign r_ord     = rd1_q[EW-1 -: KeyBits] ^ SignBit;
  assign left_wins = asc_q ? (l_ord < r_ord) : (l_ord > r_ord);
  assign i_live    = (i_q <= CW'(mid_q));
  assign j_live    = (j_q <= CW'(hi_q));
  assign take_left = i_live && (!j_live || left_wins);

  mse_sorter #(
    .MaxItems (MaxItems)
  ) u_sorter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (sort_start),
    .last_idx_i   (last_idx),
    .merge_done_i (merge_done),
    .req_o        (req),
    .done_o       (sort_done)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mse_pkg::CORE_LOAD: begin
        if (sort_start) state_d = mse_pkg::CORE_SORT;
      end
      mse_pkg::CORE_SORT: begin
        if (req.valid) begin
          state_d = mse_pkg::CORE_MERGE;
        end else if (sort_done) begin
          state_d = mse_pkg::CORE_EMIT;
        end
      end
      mse_pkg::CORE_MERGE: begin
        if (k_q == CW'(hi_q)) state_d = mse_pkg::CORE_COPY;
      end
      mse_pkg::CORE_COPY: begin
        if (k_q == CW'(hi_q)) state_d = mse_pkg::CORE_SORT;
      end
      mse_pkg::CORE_EMIT: begin
        if (out_load && emit_last) state_d = mse_pkg::CORE_LOAD;
      end
      default: state_d = mse_pkg::CORE_LOAD;
    endcase
  end

  // Datapath control
  always_comb begin
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    a_we        = 1'b0;
    a_waddr     = count_q[AW-1:0];
    a_wdata     = {key_in, tag_i};
    b_we        = 1'b0;
    b_wdata     = take_left ? rd0_q : rd1_q;
    merge_done  = 1'b0;
    case (state_q)
      mse_pkg::CORE_LOAD: begin
        // store the beat unless the set is full
        if (in_acc && (count_q != CW'(MaxItems))) begin
          a_we    = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      mse_pkg::CORE_SORT: begin
        if (req.valid) begin
          // prime both run heads
          lo_d  = AW'(req.low);
          mid_d = AW'(req.mid);
          hi_d  = AW'(req.high);
          i_d   = CW'(AW'(req.low));
          j_d   = CW'(AW'(req.mid)) + CW'(1);
          k_d   = CW'(AW'(req.low));
        end else if (sort_done) begin
          i_d = '0;
        end
      end
      mse_pkg::CORE_MERGE: begin
        // move the winning head into scratch
        b_we = 1'b1;
        if (take_left) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        if (k_q == CW'(hi_q)) begin
          k_d = CW'(lo_q);
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      mse_pkg::CORE_COPY: begin
        // write the merged range back
        a_we    = 1'b1;
        a_waddr = k_q[AW-1:0];
        a_wdata = rdb_q;
        if (k_q == CW'(hi_q)) begin
          merge_done = 1'b1;
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      mse_pkg::CORE_EMIT: begin
        // advance when the output register frees up
        if (out_load) begin
          out_valid_d = 1'b1;
          out_key_d   = key_out_ext[mse_pkg::KeyW-1:0];
          out_tag_d   = rd0_q[mse_pkg::TagW-1:0];
          out_last_d  = emit_last;
          i_d         = i_q + CW'(1);
          if (emit_last) count_d = '0;
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mse_pkg::CORE_LOAD;
      count_q     <= '0;
      asc_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      asc_q       <= asc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    lo_q       <= lo_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    out_key_q  <= out_key_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  // Element memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (a_we) elem_mem[a_waddr] <= a_wdata;
    rd0_q <= elem_mem[i_d[AW-1:0]];
    rd1_q <= elem_mem[j_d[AW-1:0]];
  end

  // Scratch memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (b_we) scratch_mem[k_q[AW-1:0]] <= b_wdata;
    rdb_q <= scratch_mem[k_d[AW-1:0]];
  end

endmodule
